// ===== rtl/sce_pkg.sv =====
`timescale 1ns / 1ps

package sce_pkg;

	// Default number of keys the store can hold.
	localparam int CAPACITY_DEF = 16;

	// Fixed field widths of the request and response words.
	localparam int MODE_W = 2;
	localparam int KEY_W  = 8;
	localparam int POS_W  = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_FIND   = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	// Read address sources for the key memory.
	typedef enum logic [1:0] {
		RD_PTR,
		RD_PTR_DN,
		RD_PTR_UP,
		RD_IDX
	} rd_sel_t;

	// Write data sources for the key memory.
	typedef enum logic {
		WR_KEY,
		WR_RDATA
	} wr_sel_t;

	typedef struct packed {
		logic    load_item;
		logic    ptr_load_cnt;
		logic    ptr_clr;
		logic    ptr_inc;
		logic    ptr_dec;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    out_load;
		logic    res_ok;
	} sce_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  cnt_full;
		logic  cnt_zero;
		logic  ptr_zero;
		logic  ptr_at_cnt;
		logic  ptr_last;
		logic  rd_ge_key;
		logic  rd_eq_key;
		logic  out_busy;
	} sce_stat_t;

endpackage

// ===== rtl/sce_if.sv =====
`timescale 1ns / 1ps

// Request channel: one operation word.
interface sce_req_if import sce_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic signed [KEY_W-1:0]  key;
	logic [POS_W-1:0]         index;

	modport source (output valid, output mode, output key, output index, input ready);
	modport sink   (input valid, input mode, input key, input index, output ready);
endinterface

// Response channel: one result word.
interface sce_rsp_if import sce_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     ok;
	logic [POS_W-1:0]         position;
	logic signed [KEY_W-1:0]  value;
	logic [POS_W-1:0]         count;

	modport source (output valid, output ok, output position, output value, output count,
		input ready);
	modport sink   (input valid, input ok, input position, input value, input count,
		output ready);
endinterface

// ===== rtl/sce_ctrl.sv =====
`timescale 1ns / 1ps

module sce_ctrl import sce_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  sce_stat_t stat,
	output sce_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_RD,
		S_INS_CMP,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_READ_WAIT,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   ok_q, ok_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ok_d    = ok_q;
		cmd     = '0;
		cmd.rd_sel = RD_PTR;
		cmd.wr_sel = WR_KEY;
		cmd.res_ok = ok_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.mode)
					MODE_INSERT: begin
						if (stat.cnt_full) begin
							ok_d    = 1'b0;
							state_d = S_DONE;
						end else begin
							cmd.ptr_load_cnt = 1'b1;
							state_d          = S_INS_RD;
						end
					end
					MODE_READ: begin
						if (stat.cnt_zero) begin
							ok_d    = 1'b0;
							state_d = S_DONE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_IDX;
							state_d    = S_READ_WAIT;
						end
					end
					default: begin
						cmd.ptr_clr = 1'b1;
						state_d     = S_SRCH_RD;
					end
				endcase
			end
			S_INS_RD: begin
				if (stat.ptr_zero) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = WR_KEY;
					cmd.cnt_inc = 1'b1;
					ok_d        = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_DN;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				cmd.wr_en = 1'b1;
				if (stat.rd_ge_key) begin
					cmd.wr_sel  = WR_RDATA;
					cmd.ptr_dec = 1'b1;
					state_d     = S_INS_RD;
				end else begin
					cmd.wr_sel  = WR_KEY;
					cmd.cnt_inc = 1'b1;
					ok_d        = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_SRCH_RD: begin
				if (stat.ptr_at_cnt) begin
					ok_d    = 1'b0;
					state_d = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR;
					state_d    = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (stat.rd_eq_key) begin
					if (stat.mode == MODE_FIND) begin
						ok_d    = 1'b1;
						state_d = S_DONE;
					end else begin
						state_d = S_SHIFT_RD;
					end
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_SRCH_RD;
				end
			end
			S_SHIFT_RD: begin
				if (stat.ptr_last) begin
					cmd.cnt_dec = 1'b1;
					ok_d        = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_UP;
					state_d    = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_RDATA;
				cmd.ptr_inc = 1'b1;
				state_d     = S_SHIFT_RD;
			end
			S_READ_WAIT: begin
				ok_d    = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
		end
	end

endmodule

// ===== rtl/sce_datapath.sv =====
`timescale 1ns / 1ps

module sce_datapath import sce_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [MODE_W-1:0]       req_mode,
	input  logic signed [KEY_W-1:0] req_key,
	input  logic [POS_W-1:0]        req_index,
	input  sce_cmd_t                cmd,
	output sce_stat_t               stat,
	sce_rsp_if.source               rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > POS_W) ? CW : POS_W;
	localparam int PW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

	logic signed [KEY_W-1:0] mem [CAPACITY];
	logic signed [KEY_W-1:0] rd_q;
	logic [MODE_W-1:0]       mode_q;
	logic signed [KEY_W-1:0] key_q;
	logic [POS_W-1:0]        index_q;
	logic [CW-1:0]           ptr_q;
	logic [CW-1:0]           count_q;
	logic                    out_vld_q;
	logic                    out_ok_q;
	logic [POS_W-1:0]        out_pos_q;
	logic signed [KEY_W-1:0] out_val_q;
	logic [POS_W-1:0]        out_cnt_q;

	logic [CW:0]             ptr_up;
	logic [CW-1:0]           ptr_dn;
	logic [EW-1:0]           idx_ext;
	logic [EW-1:0]           cnt_ext;
	logic [EW-1:0]           idx_c;
	logic [EW-1:0]           idx_m1;
	logic [PW-1:0]           pos_ext;
	logic [AW-1:0]           rd_addr;
	logic signed [KEY_W-1:0] wr_data;

	assign ptr_up  = {1'b0, ptr_q} + {{CW{1'b0}}, 1'b1};
	assign ptr_dn  = ptr_q - {{(CW-1){1'b0}}, 1'b1};
	assign idx_ext = EW'(index_q);
	assign cnt_ext = EW'(count_q);
	assign pos_ext = PW'(ptr_up);

	// Clamp the read position to 1..count.
	always_comb begin
		if (idx_ext == '0) begin
			idx_c = {{(EW-1){1'b0}}, 1'b1};
		end else if (idx_ext > cnt_ext) begin
			idx_c = cnt_ext;
		end else begin
			idx_c = idx_ext;
		end
	end
	assign idx_m1 = idx_c - {{(EW-1){1'b0}}, 1'b1};

	always_comb begin
		case (cmd.rd_sel)
			RD_PTR:    rd_addr = ptr_q[AW-1:0];
			RD_PTR_DN: rd_addr = ptr_dn[AW-1:0];
			RD_PTR_UP: rd_addr = ptr_up[AW-1:0];
			RD_IDX:    rd_addr = idx_m1[AW-1:0];
			default:   rd_addr = ptr_q[AW-1:0];
		endcase
	end

	assign wr_data = (cmd.wr_sel == WR_RDATA) ? rd_q : key_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[ptr_q[AW-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q  <= req_mode;
			key_q   <= req_key;
			index_q <= req_index;
		end
		if (cmd.ptr_load_cnt) begin
			ptr_q <= count_q;
		end else if (cmd.ptr_clr) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_up[CW-1:0];
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_dn;
		end
		if (cmd.out_load) begin
			out_ok_q  <= cmd.res_ok;
			out_pos_q <= (cmd.res_ok && mode_t'(mode_q) == MODE_FIND) ?
				pos_ext[POS_W-1:0] : '0;
			out_val_q <= (cmd.res_ok && mode_t'(mode_q) == MODE_READ) ? rd_q : '0;
			out_cnt_q <= cnt_ext[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - {{(CW-1){1'b0}}, 1'b1};
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign stat.mode       = mode_t'(mode_q);
	assign stat.cnt_full   = (count_q == CW'(CAPACITY));
	assign stat.cnt_zero   = (count_q == '0);
	assign stat.ptr_zero   = (ptr_q == '0);
	assign stat.ptr_at_cnt = (ptr_q == count_q);
	assign stat.ptr_last   = (ptr_up >= {1'b0, count_q});
	assign stat.rd_ge_key  = (rd_q >= key_q);
	assign stat.rd_eq_key  = (rd_q == key_q);
	assign stat.out_busy   = out_vld_q && !rsp.ready;

	assign rsp.valid    = out_vld_q;
	assign rsp.ok       = out_ok_q;
	assign rsp.position = out_pos_q;
	assign rsp.value    = out_val_q;
	assign rsp.count    = out_cnt_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("stored count beyond capacity");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> ptr_q < CW'(CAPACITY))
		else $error("memory write outside the store");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !stat.cnt_full)
		else $error("insert into a full store");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_vld_q || rsp.ready))
		else $error("pending response overwritten");

endmodule

// ===== rtl/sorted_char_list_engine.sv =====
`timescale 1ns / 1ps

// Sorted list of signed 8-bit keys, ascending, up to CAPACITY entries, kept in
// a single memory with one write port and one registered read port. Each request
// word asks for insert, remove, find or read, and each gives exactly one response
// word carrying ok, the found position, the read value and the count after the
// operation. Requests are taken one at a time; the memory port sets the pace, as
// every key the controller looks at costs a read state and then a compare or
// write state. Insert walks down from the end past the stored keys not smaller
// than the new one, shifting each up; find walks up from the front to the key;
// remove walks up to the key and then shifts every later key down, and walks the
// whole list when the key is absent; read does one memory read; a full insert or
// an empty read touches no memory. Every operation is also held while the
// previous response still sits untaken in the output register. A response waits
// in that register until taken, and the next request is accepted as soon as that
// register is loaded. The store needs no clearing pass: reset clears the count,
// and entries at or beyond the count are never read.

module sorted_char_list_engine import sce_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sce_req_if.sink   req,
	sce_rsp_if.source rsp
);

	sce_cmd_t  cmd;
	sce_stat_t stat;
	logic      ctl_ready;

	// The controller only sees the handshake; the request payload goes straight
	// into the datapath item registers on the accepting edge.
	assign req.ready = ctl_ready;

	sce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ctl_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sce_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_mode  (req.mode),
		.req_key   (req.key),
		.req_index (req.index),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule
